/* rtl/fpp_pkg.sv */
// Shared types and constants for the framed pose packet parser.
package fpp_pkg;

	localparam logic [7:0] HDR_FIRST  = 8'h0D;
	localparam logic [7:0] HDR_SECOND = 8'h0A;
	localparam logic [7:0] TRL_FIRST  = 8'h0A;
	localparam logic [7:0] TRL_SECOND = 8'h0D;

	localparam int PAYLOAD_LEN = 24;
	localparam int NUM_WORDS   = PAYLOAD_LEN / 4;
	localparam int IDX_W       = $clog2(PAYLOAD_LEN + 1);

	typedef logic [IDX_W-1:0] idx_t;

	typedef struct packed {
		logic [31:0] yaw_angle_bits;
		logic [31:0] roll_angle_bits;
		logic [31:0] pitch_angle_bits;
		logic [31:0] position_x_bits;
		logic [31:0] position_y_bits;
		logic [31:0] yaw_rate_bits;
		logic        first_frame;
	} pose_t;

endpackage

/* rtl/fpp_if.sv */
// Valid/ready channel interfaces for received bytes and decoded pose words.
interface fpp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface fpp_pose_if;
	logic           valid;
	logic           ready;
	fpp_pkg::pose_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/fpp_framer.sv */
// Header/trailer phase machine and payload byte store.
module fpp_framer (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           take,
	input  logic [7:0]     rx_byte,
	output logic           frame_done,
	output fpp_pkg::pose_t result
);

	localparam logic [2:0] PH_HUNT = 3'd0;
	localparam logic [2:0] PH_LF   = 3'd1;
	localparam logic [2:0] PH_PAY  = 3'd2;
	localparam logic [2:0] PH_TRL1 = 3'd3;
	localparam logic [2:0] PH_TRL2 = 3'd4;

	localparam fpp_pkg::idx_t LEN = fpp_pkg::idx_t'(fpp_pkg::PAYLOAD_LEN);

	logic [2:0]          phase_q;
	logic [2:0]          phase_d;
	fpp_pkg::idx_t       byte_idx_q;
	fpp_pkg::idx_t       byte_idx_d;
	fpp_pkg::idx_t       idx_inc;
	logic                seen_q;
	logic                wr_en;
	logic [7:0]          store_q [fpp_pkg::PAYLOAD_LEN];
	logic [31:0]         words [fpp_pkg::NUM_WORDS];

	assign idx_inc = byte_idx_q + fpp_pkg::idx_t'(1);

	always_comb begin
		phase_d    = phase_q;
		byte_idx_d = byte_idx_q;
		wr_en      = 1'b0;
		frame_done = 1'b0;
		case (phase_q)
			PH_HUNT: begin
				phase_d = (rx_byte == fpp_pkg::HDR_FIRST) ? PH_LF : PH_HUNT;
			end
			PH_LF: begin
				if (rx_byte == fpp_pkg::HDR_SECOND) begin
					byte_idx_d = '0;
					phase_d    = PH_PAY;
				end else if (rx_byte != fpp_pkg::HDR_FIRST) begin
					phase_d = PH_HUNT;
				end
			end
			PH_PAY: begin
				if (byte_idx_q < LEN) begin
					wr_en      = 1'b1;
					byte_idx_d = idx_inc;
				end else begin
					byte_idx_d = LEN;
				end
				// last slot filled: go look for the trailer
				if (byte_idx_d >= LEN) begin
					byte_idx_d = '0;
					phase_d    = PH_TRL1;
				end
			end
			PH_TRL1: begin
				phase_d = (rx_byte == fpp_pkg::TRL_FIRST) ? PH_TRL2 : PH_HUNT;
			end
			PH_TRL2: begin
				frame_done = take && (rx_byte == fpp_pkg::TRL_SECOND);
				phase_d    = PH_HUNT;
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HUNT;
			byte_idx_q <= '0;
			seen_q     <= 1'b0;
		end else if (take) begin
			phase_q    <= phase_d;
			byte_idx_q <= byte_idx_d;
			if (frame_done) begin
				seen_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && wr_en) begin
			store_q[byte_idx_q] <= rx_byte;
		end
	end

	// assemble little-endian words from the stored bytes
	always_comb begin
		for (int k = 0; k < fpp_pkg::NUM_WORDS; k++) begin
			words[k] = {store_q[4*k+3], store_q[4*k+2], store_q[4*k+1], store_q[4*k]};
		end
	end

	assign result.yaw_angle_bits   = words[0];
	assign result.roll_angle_bits  = words[1];
	assign result.pitch_angle_bits = words[2];
	assign result.position_x_bits  = words[3];
	assign result.position_y_bits  = words[4];
	assign result.yaw_rate_bits    = words[5];
	assign result.first_frame      = !seen_q;

`ifndef SYNTH
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		byte_idx_q < LEN)
		else $error("payload index past end of store");

	a_idx_only_in_payload: assert property (@(posedge clk) disable iff (!arst_n)
		byte_idx_q != '0 |-> phase_q == PH_PAY)
		else $error("payload index nonzero outside payload phase");

	a_seen_from_frame: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(seen_q) |-> $past(frame_done))
		else $error("first-frame flag set without a complete frame");
`endif

endmodule

/* rtl/fpp_out_stage.sv */
// Result register that holds a decoded frame until the sink takes it.
module fpp_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  fpp_pkg::pose_t    result,
	fpp_pose_if.source        pose
);

	logic           valid_q;
	fpp_pkg::pose_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (pose.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= result;
		end
	end

	assign pose.valid = valid_q;
	assign pose.data  = data_q;

endmodule

/* rtl/framed_pose_packet_parser.sv */
// Top level of the framed pose packet parser.
//
//   port  dir   word                      fields
//   rx    sink  one received serial byte  rx_byte[7:0]
//   pose  src   one decoded frame         six 32-bit words, first_frame
//
// One byte is taken per cycle while rx is not stalled; the phase machine and store update on the accepting edge.
// A completed frame appears on pose in the cycle after its closing trailer byte is taken.
// Reset clears the phase, payload index and first-frame flag; the byte store is not cleared.
// rx stalls only while a decoded frame waits on pose and pose.ready is low.
module framed_pose_packet_parser (
	input  logic       clk,
	input  logic       arst_n,
	fpp_byte_if.sink   rx,
	fpp_pose_if.source pose
);

	logic           take;
	logic           frame_done;
	fpp_pkg::pose_t result;

	assign rx.ready = !pose.valid || pose.ready;
	assign take     = rx.valid && rx.ready;

	fpp_framer u_framer (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.rx_byte    (rx.rx_byte),
		.frame_done (frame_done),
		.result     (result)
	);

	fpp_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (frame_done),
		.result (result),
		.pose   (pose)
	);

endmodule

/* verif/tb_framed_pose_packet_parser.sv */
// Testbench for the framed pose packet parser: random byte streams, scoreboard of decoded frames.
`timescale 1ns / 100ps

module tb_framed_pose_packet_parser;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int STREAM_BYTES = 1140;
	localparam int TAIL_CYCLES  = 10;
	localparam int REPORT_MAX   = 10;

	typedef enum logic [1:0] {PACE_FULL, PACE_SRC, PACE_SNK, PACE_BOTH} pace_t;
	typedef enum logic [2:0] {SCAN_CR, SCAN_LF, TAKE_LOAD, WANT_LF, WANT_CR} scan_t;

	typedef logic [7:0] load_t [fpp_pkg::PAYLOAD_LEN];

	typedef struct {
		logic [7:0] b;
		pace_t      pace;
		bit         hold;
	} rx_item_t;

	logic clk = 1'b0;
	logic arst_n;

	fpp_byte_if rx_if ();
	fpp_pose_if pose_if ();

	framed_pose_packet_parser dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if.sink),
		.pose   (pose_if.source)
	);

	always #5 clk = ~clk;

	rx_item_t        bytes_pending[$];
	fpp_pkg::pose_t  frames_due[$];
	int              frames_open = 0;
	pace_t           cur_pace = PACE_FULL;
	bit              hold_seen = 1'b0;
	int              err_cnt = 0;
	int              bytes_in = 0;
	int              frames_in = 0;
	int              cycles = 0;

	// Parser shadow state
	scan_t          scan = SCAN_CR;
	fpp_pkg::idx_t  load_idx = '0;
	logic [7:0]     load_buf [fpp_pkg::PAYLOAD_LEN];
	bit             frame_seen = 1'b0;

	function automatic logic [31:0] load_word(input int k);
		return {load_buf[4*k+3], load_buf[4*k+2], load_buf[4*k+1], load_buf[4*k]};
	endfunction

	task automatic decode_rx_byte(input logic [7:0] b);
		fpp_pkg::pose_t f;
		case (scan)
			SCAN_CR: begin
				scan = (b == fpp_pkg::HDR_FIRST) ? SCAN_LF : SCAN_CR;
			end
			SCAN_LF: begin
				if (b == fpp_pkg::HDR_SECOND) begin
					load_idx = '0;
					scan = TAKE_LOAD;
				end else if (b != fpp_pkg::HDR_FIRST) begin
					scan = SCAN_CR;
				end
			end
			TAKE_LOAD: begin
				if (load_idx < fpp_pkg::PAYLOAD_LEN) begin
					load_buf[load_idx] = b;
					load_idx = load_idx + 1'b1;
				end
				if (load_idx >= fpp_pkg::PAYLOAD_LEN) begin
					load_idx = '0;
					scan = WANT_LF;
				end
			end
			WANT_LF: begin
				scan = (b == fpp_pkg::TRL_FIRST) ? WANT_CR : SCAN_CR;
			end
			WANT_CR: begin
				if (b == fpp_pkg::TRL_SECOND) begin
					f.yaw_angle_bits   = load_word(0);
					f.roll_angle_bits  = load_word(1);
					f.pitch_angle_bits = load_word(2);
					f.position_x_bits  = load_word(3);
					f.position_y_bits  = load_word(4);
					f.yaw_rate_bits    = load_word(5);
					f.first_frame      = !frame_seen;
					frame_seen = 1'b1;
					frames_due.push_back(f);
				end
				scan = SCAN_CR;
			end
			default: begin
				scan = SCAN_CR;
			end
		endcase
	endtask

	task automatic check_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			err_cnt++;
			if (err_cnt <= REPORT_MAX)
				$display("MISMATCH frame %0d %s: expected %08h, got %08h",
					frames_in, field, want, got);
		end
	endtask

	task automatic queue_byte(input logic [7:0] b, input pace_t pace, input bit hold);
		rx_item_t it;
		it.b    = b;
		it.pace = pace;
		it.hold = hold;
		bytes_pending.push_back(it);
	endtask

	task automatic queue_frame(input load_t pl, input int extra_cr, input logic [7:0] t1,
			input logic [7:0] t2, input pace_t pace, input bit hold);
		queue_byte(fpp_pkg::HDR_FIRST, pace, hold);
		repeat (extra_cr) queue_byte(fpp_pkg::HDR_FIRST, pace, 1'b0);
		queue_byte(fpp_pkg::HDR_SECOND, pace, 1'b0);
		for (int i = 0; i < fpp_pkg::PAYLOAD_LEN; i++)
			queue_byte(pl[i], pace, 1'b0);
		queue_byte(t1, pace, 1'b0);
		queue_byte(t2, pace, 1'b0);
	endtask

	// Byte driver: hold a word until taken, then pick the next one or idle.
	always @(posedge clk or negedge arst_n) begin : drive_rx
		logic gap;
		if (!arst_n) begin
			rx_if.valid   <= 1'b0;
			rx_if.rx_byte <= '0;
			hold_seen     <= 1'b0;
		end else if (!rx_if.valid || rx_if.ready) begin
			gap = 1'b0;
			if (bytes_pending.size() != 0) begin
				gap = (bytes_pending[0].pace == PACE_SRC && $urandom_range(99) < 64) ||
					(bytes_pending[0].pace == PACE_BOTH && $urandom_range(99) < 11);
			end
			if (bytes_pending.size() == 0) begin
				rx_if.valid <= 1'b0;
			end else if (bytes_pending[0].hold && !hold_seen) begin
				// idle first so the count of open frames catches up
				rx_if.valid <= 1'b0;
				hold_seen   <= 1'b1;
			end else if ((bytes_pending[0].hold && frames_open != 0) || gap) begin
				rx_if.valid <= 1'b0;
			end else begin
				rx_if.valid   <= 1'b1;
				rx_if.rx_byte <= bytes_pending[0].b;
				cur_pace      <= bytes_pending[0].pace;
				hold_seen     <= 1'b0;
				void'(bytes_pending.pop_front());
			end
		end
	end

	// Pose monitor and scoreboard; also predicts on every accepted byte.
	always @(posedge clk or negedge arst_n) begin : watch_pose
		fpp_pkg::pose_t want;
		fpp_pkg::pose_t got;
		if (!arst_n) begin
			pose_if.ready <= 1'b0;
			frames_open   <= 0;
		end else begin
			if (pose_if.valid && pose_if.ready) begin
				got = pose_if.data;
				frames_in++;
				if (frames_due.size() == 0) begin
					err_cnt++;
					if (err_cnt <= REPORT_MAX)
						$display("MISMATCH unexpected frame %0d: yaw %08h first %0b",
							frames_in, got.yaw_angle_bits, got.first_frame);
				end else begin
					want = frames_due.pop_front();
					check_field("yaw_angle_bits", want.yaw_angle_bits, got.yaw_angle_bits);
					check_field("roll_angle_bits", want.roll_angle_bits, got.roll_angle_bits);
					check_field("pitch_angle_bits", want.pitch_angle_bits,
						got.pitch_angle_bits);
					check_field("position_x_bits", want.position_x_bits, got.position_x_bits);
					check_field("position_y_bits", want.position_y_bits, got.position_y_bits);
					check_field("yaw_rate_bits", want.yaw_rate_bits, got.yaw_rate_bits);
					check_field("first_frame", 32'(want.first_frame), 32'(got.first_frame));
				end
			end
			if (rx_if.valid && rx_if.ready) begin
				bytes_in++;
				decode_rx_byte(rx_if.rx_byte);
			end
			frames_open <= frames_due.size();
			case (cur_pace)
				PACE_SNK:  pose_if.ready <= ($urandom_range(99) >= 64);
				PACE_BOTH: pose_if.ready <= ($urandom_range(99) >= 11);
				default:   pose_if.ready <= 1'b1;
			endcase
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d frames still open", cycles,
				frames_due.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		logic [31:0] edge_words [fpp_pkg::NUM_WORDS];
		load_t       pl;
		int          kind;
		int          crs;
		int          q;
		pace_t       pace;
		pace_t       last_pace;
		bit          hold;
		logic [7:0]  t1;
		logic [7:0]  t2;

		edge_words = '{32'hFFFF_FFFF, 32'h0000_0000,
			32'h0D0A_0D0A, 32'h0A0D_0A0D, 32'h8000_0000, 32'h7F80_0000};

		arst_n        = 1'b0;
		rx_if.valid   = 1'b0;
		rx_if.rx_byte = '0;
		pose_if.ready = 1'b0;

		// Hunt noise, a lone LF, a broken header, then a frame behind repeated CRs
		queue_byte(8'h00, PACE_FULL, 1'b0);
		queue_byte(8'hFF, PACE_FULL, 1'b0);
		queue_byte(fpp_pkg::HDR_SECOND, PACE_FULL, 1'b0);
		queue_byte(fpp_pkg::HDR_FIRST, PACE_FULL, 1'b0);
		queue_byte(8'h41, PACE_FULL, 1'b0);
		for (int i = 0; i < fpp_pkg::PAYLOAD_LEN; i++)
			pl[i] = edge_words[i / 4][8 * (i % 4) +: 8];
		queue_frame(pl, 2, fpp_pkg::TRL_FIRST, fpp_pkg::TRL_SECOND, PACE_FULL, 1'b0);

		last_pace = PACE_FULL;
		while (bytes_pending.size() < STREAM_BYTES) begin
			q = bytes_pending.size() * 4 / STREAM_BYTES;
			pace = pace_t'(q > 3 ? 3 : q);
			hold = (pace != last_pace) || ($urandom_range(11) == 0);
			last_pace = pace;
			kind = $urandom_range(99);
			if (kind >= 88) begin
				// header broken after the CR, then some noise
				queue_byte(fpp_pkg::HDR_FIRST, pace, hold);
				t1 = 8'($urandom);
				if (t1 == fpp_pkg::HDR_SECOND)
					t1 = 8'h00;
				queue_byte(t1, pace, 1'b0);
				repeat ($urandom_range(0, 4)) queue_byte(8'($urandom), pace, 1'b0);
			end else begin
				for (int i = 0; i < fpp_pkg::PAYLOAD_LEN; i++) begin
					case ($urandom_range(7))
						0:       pl[i] = fpp_pkg::HDR_FIRST;
						1:       pl[i] = fpp_pkg::HDR_SECOND;
						default: pl[i] = 8'($urandom);
					endcase
				end
				crs = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
				t1 = fpp_pkg::TRL_FIRST;
				t2 = fpp_pkg::TRL_SECOND;
				if (kind >= 70 && kind < 80) begin
					t1 = $urandom_range(1) ? fpp_pkg::HDR_FIRST : 8'($urandom);
					while (t1 == fpp_pkg::TRL_FIRST)
						t1 = 8'($urandom);
					t2 = $urandom_range(1) ? fpp_pkg::HDR_SECOND : 8'($urandom);
				end else if (kind >= 80) begin
					t2 = $urandom_range(1) ? fpp_pkg::TRL_FIRST : 8'($urandom);
					while (t2 == fpp_pkg::TRL_SECOND)
						t2 = 8'($urandom);
				end
				queue_frame(pl, crs, t1, t2, pace, hold);
			end
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		@(negedge clk);
		while (bytes_pending.size() != 0 || rx_if.valid)
			@(negedge clk);
		while (frames_open != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("Run covered %0d bytes and %0d decoded frames in %0d cycles,",
			bytes_in, frames_in, cycles);
		$display("under free, sender-gap, receiver-stall and mixed pacing.");
		if (err_cnt == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
